// ===== rtl/mbrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrc_pkg: shared types and constants
// Status codes, register indexes, frame constants and the byte-wide CRC-16
// update for the read-holding-registers reply checker.
// ----------------------------------------------------------------------------
package mbrc_pkg;

  localparam int MAX_REGS  = 6;
  localparam int COUNT_W   = $clog2(MAX_REGS + 1);
  localparam int INDEX_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [4:0]  POS_MAX = 5'd31;

  // result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_CRC   = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_FUNC  = 3'd3;
  localparam logic [2:0] ST_COUNT = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGISTER_COUNT = 2'd1;

  // one checked frame, handed to the result stage
  typedef struct packed {
    logic [2:0]                    status;
    logic [COUNT_W-1:0]            count;
    logic [MAX_REGS-1:0][15:0]     words;
  } frame_result_t;

  // reflected CRC-16 update over one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mbrc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrc_if: byte and result channels
// Valid/ready channels for received bytes and for checked register results.
// ----------------------------------------------------------------------------
interface mbrc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, rx_byte, frame_end, input ready);
  modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface

interface mbrc_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  register_index;
  logic [15:0] register_value;
  logic        last_result;

  modport source (output valid, status, register_index, register_value, last_result,
                  input ready);
  modport sink   (input valid, status, register_index, register_value, last_result,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/modbus_rtu_read_response_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_read_response_checker: Modbus RTU read-holding-registers reply
// Checks one reply frame byte by byte and emits its register words or a
// single error status.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one beat per received byte; frame_end marks the last byte of a frame.
//   res : on a good frame, register_count beats (status 0, index 0..count-1,
//         word high byte first on the wire), last_result on the final one. On a
//         bad frame one beat with status 1..4, index and value 0, last set.
//   cfg : cfg_we writes cfg_data to register cfg_index (0 slave address,
//         1 register count); write only while the block is idle.
// Latency: a frame's first result beat is valid the cycle after its last byte
//   is taken. The CRC update of the byte two places back and all frame checks
//   sit in one stage ahead of the state registers.
// Throughput: one byte per cycle. Mid-frame bytes are taken while earlier
//   results still drain; a frame_end byte waits only while the result buffer
//   still holds more than one beat (or one beat that is not being taken).
// Reset (rst, synchronous): CRC to 0xFFFF, byte counter and header bytes
//   cleared, result buffer emptied, slave address 1, register count 6.
// Stall: while res.ready is low the current beat holds; bytes keep coming in
//   until the next frame_end byte.
// ----------------------------------------------------------------------------
module modbus_rtu_read_response_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [mbrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mbrc_pkg::CFG_DATA_W-1:0] cfg_data,
  mbrc_rx_if.sink                              rx,
  mbrc_res_if.source                           res
);
  import mbrc_pkg::*;

  // configuration
  logic [7:0] slave_address;
  logic [2:0] register_count;

  // frame state
  logic [15:0]               crc;
  logic [4:0]                pos;
  logic [7:0]                trail0;
  logic [7:0]                trail1;
  logic [2:0][7:0]           header;
  logic [7:0]                pending_high;
  logic [MAX_REGS-1:0][15:0] reg_store;

  logic          accept;
  logic          can_load;
  logic [15:0]   crc_next;
  logic [4:0]    pos_next;
  logic [4:0]    frame_len;
  logic [15:0]   rx_crc;
  logic [3:0]    word_idx;
  logic          low_byte;
  logic [2:0]    status_sel;
  frame_result_t frame;

  // a frame_end byte needs room in the result buffer
  assign rx.ready = !rx.frame_end || can_load;
  assign accept   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address  <= 8'd1;
      register_count <= 3'd6;
    end else if (cfg_we) begin
      if (cfg_index == REG_SLAVE_ADDRESS) begin
        slave_address <= cfg_data;
      end else if (cfg_index == REG_REGISTER_COUNT) begin
        register_count <= cfg_data[2:0];
      end
    end
  end

  // the byte two places back joins the CRC once two bytes are held
  assign crc_next  = (pos >= 5'd2) ? crc_feed(crc, trail0) : crc;
  assign pos_next  = (pos == POS_MAX) ? pos : pos + 5'd1;
  assign frame_len = {1'b0, register_count, 1'b0} + 5'd5;
  assign rx_crc    = {rx.rx_byte, trail1};

  // register words: high byte at odd offset past the header, low byte next
  assign low_byte = (pos >= 5'd4) && !pos[0];
  assign word_idx = pos[4:1] - 4'd2;

  always_comb begin
    priority if (pos_next != frame_len || rx_crc != crc_next) begin
      status_sel = ST_CRC;
    end else if (header[0] != slave_address) begin
      status_sel = ST_ADDR;
    end else if (header[1] != FUNC_READ_HOLDING) begin
      status_sel = ST_FUNC;
    end else if (register_count == 3'd0 || {1'b0, register_count} > 4'(MAX_REGS) ||
                 header[2] != {4'd0, register_count, 1'b0}) begin
      status_sel = ST_COUNT;
    end else begin
      status_sel = ST_OK;
    end
  end

  always_comb begin
    frame.status = status_sel;
    if (status_sel == ST_OK) begin
      frame.count = COUNT_W'(register_count);
      frame.words = reg_store;
    end else begin
      frame.count = COUNT_W'(1);
      frame.words = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc          <= CRC_INIT;
      pos          <= '0;
      trail0       <= '0;
      trail1       <= '0;
      header       <= '0;
      pending_high <= '0;
    end else if (accept) begin
      if (rx.frame_end) begin
        crc          <= CRC_INIT;
        pos          <= '0;
        trail0       <= '0;
        trail1       <= '0;
        header       <= '0;
        pending_high <= '0;
      end else begin
        crc    <= crc_next;
        pos    <= pos_next;
        trail0 <= trail1;
        trail1 <= rx.rx_byte;
        if (pos < 5'd3) begin
          header[pos[1:0]] <= rx.rx_byte;
        end else if (pos[0]) begin
          pending_high <= rx.rx_byte;
        end
      end
    end
  end

  // word store: no reset, only entries written in this frame are read
  for (genvar i = 0; i < MAX_REGS; i++) begin : g_store
    always_ff @(posedge clk) begin
      if (accept && low_byte && word_idx == 4'(i)) begin
        reg_store[i] <= {pending_high, rx.rx_byte};
      end
    end
  end

  mbrc_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && rx.frame_end),
    .frame    (frame),
    .can_load (can_load),
    .res      (res)
  );

endmodule
`default_nettype wire

// ===== rtl/mbrc_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrc_emit: result beat sequencer
// Holds one checked frame and plays it out as result beats, one register
// word per beat, through a shift buffer.
// ----------------------------------------------------------------------------
module mbrc_emit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire mbrc_pkg::frame_result_t frame,
  output logic                       can_load,
  mbrc_res_if.source                 res
);
  import mbrc_pkg::*;

  logic [COUNT_W-1:0]        remaining;
  logic [INDEX_W-1:0]        index;
  logic [2:0]                status;
  logic [MAX_REGS-1:0][15:0] words;
  logic                      take;

  assign take     = res.valid && res.ready;
  // free now, or the final beat leaves this cycle
  assign can_load = (remaining == '0) ||
                    ((remaining == COUNT_W'(1)) && res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      index     <= '0;
      status    <= ST_OK;
    end else if (load) begin
      remaining <= frame.count;
      index     <= '0;
      status    <= frame.status;
    end else if (take) begin
      remaining <= remaining - COUNT_W'(1);
      index     <= index + INDEX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      words <= frame.words;
    end else if (take) begin
      words <= {16'h0000, words[MAX_REGS-1:1]};
    end
  end

  assign res.valid          = (remaining != '0);
  assign res.status         = status;
  assign res.register_index = index;
  assign res.register_value = words[0];
  assign res.last_result    = (remaining == COUNT_W'(1));

endmodule
`default_nettype wire

// ===== rtl/mbrc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrc_checker: port-level checks
// Watches the byte and result channels of the reply checker over time.
// ----------------------------------------------------------------------------
module mbrc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rx_valid,
  input wire logic        rx_ready,
  input wire logic        rx_frame_end,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [2:0]  res_status,
  input wire logic [2:0]  res_register_index,
  input wire logic [15:0] res_register_value,
  input wire logic        res_last_result
);
  import mbrc_pkg::*;

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_register_value) &&
                                $stable(res_register_index))
    else $error("result beat changed while stalled");

  // an error frame yields one cleared, final beat
  a_err: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_OK |->
      res_last_result && res_register_index == 3'd0 && res_register_value == 16'h0000)
    else $error("error beat not single and cleared");

  // a taken non-final beat is followed by the next register
  a_seq: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_last_result |=>
      res_valid && res_register_index == $past(res_register_index) + 3'd1)
    else $error("register sequence broken");

  // a mid-frame byte on an idle output produces no result
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    rx_valid && rx_ready && !rx_frame_end && !res_valid |=> !res_valid)
    else $error("result without frame end");

endmodule

bind modbus_rtu_read_response_checker mbrc_checker u_chk (
  .clk                (clk),
  .rst                (rst),
  .rx_valid           (rx.valid),
  .rx_ready           (rx.ready),
  .rx_frame_end       (rx.frame_end),
  .res_valid          (res.valid),
  .res_ready          (res.ready),
  .res_status         (res.status),
  .res_register_index (res.register_index),
  .res_register_value (res.register_value),
  .res_last_result    (res.last_result)
);
`default_nettype wire

// ===== tb/sv/tb_modbus_rtu_read_response_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_read_response_checker: self-checking bench for the reply checker
// Feeds Modbus RTU read-holding-registers reply frames one byte per beat:
// good frames with random words, and frames with a wrong address, function,
// byte count, CRC or length, plus short, long and noise frames. An in-bench
// predictor tracks CRC, header and register words and queues the beats each
// frame should produce. Result beats are checked in order. Both channels idle
// at random; the config is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_read_response_checker;
  import mbrc_pkg::*;

  localparam int LIMIT       = 200000;  // cycle budget, far beyond a clean run
  localparam int IDLE_PCT    = 22;      // chance per cycle that a side idles
  localparam int LONG_HOLD   = 300;     // receiver hold-off for the back-pressure phase
  localparam int SETTLE      = 4;       // cycles after drain

  // one byte on the rx channel
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_beat_t;

  // one beat on the result channel
  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  index;
    logic [15:0] value;
    logic        last;
  } reply_beat_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mbrc_rx_if  rx_ch ();
  mbrc_res_if res_ch ();

  modbus_rtu_read_response_checker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_ch),
    .res       (res_ch)
  );

  // --------------------------------------------------------------------------
  // Predictor state: mirrors what the block holds across a frame.
  // --------------------------------------------------------------------------
  logic [15:0] crc_run;                   // CRC over all bytes but the last two
  logic [4:0]  byte_pos;                  // saturating byte counter
  logic [7:0]  tail_bytes [2];            // two newest bytes, held back from the CRC
  logic [7:0]  head_bytes [3];            // address, function, byte count
  logic [7:0]  high_pending;              // high byte waiting for its low byte
  logic [15:0] word_store [MAX_REGS];
  logic [7:0]  cur_addr;                  // config as last written
  logic [2:0]  cur_count;

  reply_beat_t reply_due [$];             // beats still owed by the block
  rx_beat_t    byte_plan [$];             // bytes waiting for the driver
  logic [7:0]  frame_buf [$];             // frame under construction

  // control between the stimulus process and the two channel processes
  logic rx_steady;                        // sender never idles
  logic res_steady;                       // receiver never stalls
  logic long_hold_req;                    // ask the receiver for one long hold-off

  int mismatches;
  int bytes_queued;                       // bytes handed to the driver so far
  int bytes_taken;
  int cycle_count;
  int hold_left;
  logic        next_ready;
  rx_beat_t    next_beat;
  reply_beat_t got_beat;
  reply_beat_t want_beat;

  // reflected CRC-16, fed one bit at a time, LSB first
  function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r  = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function void clear_frame_state();
    crc_run       = CRC_INIT;
    byte_pos      = '0;
    tail_bytes[0] = '0;
    tail_bytes[1] = '0;
    head_bytes[0] = '0;
    head_bytes[1] = '0;
    head_bytes[2] = '0;
    high_pending  = '0;
  endfunction

  // Advance the predictor by one accepted byte; on frame end queue the beats
  // the frame owes: one error beat, or one beat per register.
  function void check_reply_byte(input logic [7:0] b, input logic fin);
    logic [15:0] wire_crc;
    int          slot;
    reply_beat_t beat;
    // oldest held byte enters the CRC only once two bytes are held back
    if (byte_pos >= 2) crc_run = crc16_update(crc_run, tail_bytes[0]);
    tail_bytes[0] = tail_bytes[1];
    tail_bytes[1] = b;
    if (byte_pos < 3) begin
      head_bytes[byte_pos] = b;
    end else if (byte_pos[0]) begin
      high_pending = b;                   // positions 3, 5, ... carry high bytes
    end else begin
      slot = (int'(byte_pos) - 4) / 2;
      if (slot < MAX_REGS) word_store[slot] = {high_pending, b};
    end
    if (byte_pos != POS_MAX) byte_pos++;
    if (!fin) return;

    wire_crc = {tail_bytes[1], tail_bytes[0]};  // CRC goes low byte first
    beat = '{status: ST_OK, index: '0, value: '0, last: 1'b1};
    if (int'(byte_pos) != 2 * int'(cur_count) + 5 || wire_crc != crc_run) begin
      beat.status = ST_CRC;
    end else if (head_bytes[0] != cur_addr) begin
      beat.status = ST_ADDR;
    end else if (head_bytes[1] != FUNC_READ_HOLDING) begin
      beat.status = ST_FUNC;
    end else if (cur_count == 0 || int'(cur_count) > MAX_REGS ||
                 int'(head_bytes[2]) != 2 * int'(cur_count)) begin
      beat.status = ST_COUNT;
    end
    if (beat.status != ST_OK) begin
      reply_due.push_back(beat);
    end else begin
      for (int i = 0; i < int'(cur_count); i++) begin
        beat.index = 3'(i);
        beat.value = word_store[i];
        beat.last  = (i + 1 == int'(cur_count));
        reply_due.push_back(beat);
      end
    end
    clear_frame_state();
  endfunction

  // ---- frame construction -------------------------------------------------
  function void start_frame(input logic [7:0] addr, input logic [7:0] func,
                            input logic [7:0] bc);
    frame_buf.delete();
    frame_buf.push_back(addr);
    frame_buf.push_back(func);
    frame_buf.push_back(bc);
  endfunction

  function void add_word(input logic [15:0] w);
    frame_buf.push_back(w[15:8]);
    frame_buf.push_back(w[7:0]);
  endfunction

  function void seal_frame();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_buf[i]) c = crc16_update(c, frame_buf[i]);
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
  endfunction

  // hand the frame to the driver, frame_end on its last byte
  function void commit_frame();
    foreach (frame_buf[i]) begin
      byte_plan.push_back('{data: frame_buf[i], last: (i == frame_buf.size() - 1)});
      bytes_queued++;
    end
  endfunction

  // Mostly well-formed replies for the current config; the rest are broken
  // in one way each, or plain noise of short, long or middling length.
  function void queue_random_frame();
    int          kind;
    int          nwords;
    int          n;
    int          fi;
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [7:0]  bc;
    logic [15:0] w;
    kind = $urandom_range(0, 99);
    if (kind < 92) begin
      addr   = cur_addr;
      func   = FUNC_READ_HOLDING;
      bc     = 8'(2 * int'(cur_count));
      nwords = int'(cur_count);
      if (kind >= 65 && kind < 70) begin
        addr = cur_addr ^ 8'($urandom_range(1, 255));
      end else if (kind >= 70 && kind < 75) begin
        func = FUNC_READ_HOLDING ^ 8'($urandom_range(1, 255));
      end else if (kind >= 75 && kind < 80) begin
        bc = bc ^ 8'($urandom_range(1, 255));
      end else if (kind >= 85) begin
        nwords = $urandom_range(0, 8);
        if (nwords == int'(cur_count)) nwords++;
      end
      start_frame(addr, func, bc);
      repeat (nwords) begin
        case ($urandom_range(0, 7))
          0:       w = 16'h0000;
          1:       w = 16'hFFFF;
          default: w = 16'($urandom);
        endcase
        add_word(w);
      end
      seal_frame();
      if (kind >= 80 && kind < 85) begin
        // any single flipped bit, CRC bytes included, breaks the check
        fi = $urandom_range(0, frame_buf.size() - 1);
        frame_buf[fi] = frame_buf[fi] ^ (8'h01 << $urandom_range(0, 7));
      end
    end else begin
      if (kind < 95)      n = $urandom_range(1, 4);     // short
      else if (kind < 97) n = $urandom_range(32, 40);   // past counter saturation
      else                n = $urandom_range(5, 24);
      frame_buf.delete();
      repeat (n) frame_buf.push_back(8'($urandom));
    end
    commit_frame();
  endfunction

  // ---- config and phase control --------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] addr, input logic [2:0] cnt);
    write_reg(REG_SLAVE_ADDRESS, addr);
    cur_addr = addr;
    write_reg(REG_REGISTER_COUNT, {5'b0, cnt});
    cur_count = cnt;
  endtask

  // Every queued byte taken, everything owed has arrived, then a few cycles
  // more so the block is surely idle before a config write.
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || reply_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---- clock and timeout --------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("tb_modbus_rtu_read_response_checker: done, errors");
      $finish;
    end
  end

  // ---- rx driver: one beat per handshake, predictor fed on acceptance ------
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        check_reply_byte(rx_ch.rx_byte, rx_ch.frame_end);
        bytes_taken <= bytes_taken + 1;
      end
      // slot is free when nothing is offered or the offer was just taken
      if (!rx_ch.valid || rx_ch.ready) begin
        if (byte_plan.size() != 0 &&
            (rx_steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_beat = byte_plan.pop_front();
          rx_ch.rx_byte   <= next_beat.data;
          rx_ch.frame_end <= next_beat.last;
          rx_ch.valid     <= 1'b1;
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---- result receiver: random stalls, plus one long hold-off on request ---
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (res_steady) begin
        next_ready = 1'b1;
      end else begin
        next_ready = ($urandom_range(0, 99) >= IDLE_PCT);
      end
      res_ch.ready <= next_ready;
    end
  end

  // ---- result monitor: each beat against the oldest owed beat --------------
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      got_beat = '{status: res_ch.status, index: res_ch.register_index,
                   value: res_ch.register_value, last: res_ch.last_result};
      if (reply_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: status %0d index %0d value %h last %b",
                   got_beat.status, got_beat.index, got_beat.value, got_beat.last);
      end else begin
        want_beat = reply_due.pop_front();
        if (got_beat.status !== want_beat.status || got_beat.index !== want_beat.index ||
            got_beat.value !== want_beat.value || got_beat.last !== want_beat.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp status %0d index %0d value %h last %b, got %0d %0d %h %b",
                     want_beat.status, want_beat.index, want_beat.value, want_beat.last,
                     got_beat.status, got_beat.index, got_beat.value, got_beat.last);
        end
      end
    end
  end

  // ---- stimulus ------------------------------------------------------------
  initial begin
    int         phase;
    int         nframes;
    int         pick;
    logic [7:0] addr;
    logic [2:0] cnt;

    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_SLAVE_ADDRESS;
    cfg_data        = '0;
    rx_ch.valid     = 1'b0;
    rx_ch.rx_byte   = '0;
    rx_ch.frame_end = 1'b0;
    res_ch.ready    = 1'b0;
    long_hold_req   = 1'b0;
    rx_steady       = 1'b0;
    res_steady      = 1'b0;
    mismatches      = 0;
    bytes_queued    = 0;
    bytes_taken     = 0;
    cycle_count     = 0;
    cur_addr        = 8'h01;            // reset config: address 1, six registers
    cur_count       = 3'd6;
    clear_frame_state();
    foreach (word_store[i]) word_store[i] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: a good frame under the reset config with extreme words,
    // a one-byte frame (too short), then a zero register count, where a
    // well-formed five-byte reply must still be refused on the count check.
    start_frame(8'h01, FUNC_READ_HOLDING, 8'd12);
    add_word(16'h0000);
    add_word(16'hFFFF);
    add_word(16'h8000);
    add_word(16'h7FFF);
    add_word(16'h00FF);
    add_word(16'hFF00);
    seal_frame();
    commit_frame();
    frame_buf.delete();
    frame_buf.push_back(8'hFF);
    commit_frame();
    wait_drained();

    configure(8'h00, 3'd0);
    start_frame(8'h00, FUNC_READ_HOLDING, 8'h00);
    seal_frame();
    commit_frame();
    wait_drained();

    // Four random phases that pin the config extremes and the pressure cases.
    // Each phase ends drained, which is also where the sender pauses for all
    // owed beats.
    phase = 0;
    while (phase < 4) begin
      case (phase)
        0: begin
          addr = 8'hFF;
          cnt  = 3'd1;
        end
        1: begin
          addr = 8'($urandom);
          cnt  = 3'd6;
        end
        2: begin
          addr = 8'($urandom);
          cnt  = 3'd7;                    // above the store size
        end
        3: begin
          addr = 8'h00;
          cnt  = 3'($urandom_range(1, 6));
        end
        default: begin
          addr = 8'($urandom);
          pick = $urandom_range(0, 9);
          if (pick == 0)      cnt = 3'd0;
          else if (pick == 1) cnt = 3'd7;
          else                cnt = 3'($urandom_range(1, 6));
        end
      endcase
      configure(addr, cnt);
      rx_steady  = (phase == 1);
      res_steady = (phase == 3);
      // Phase 1: receiver holds off while the sender streams full-size frames,
      // so the result buffer fills and frame_end bytes back up.
      if (phase == 1) long_hold_req <= 1'b1;
      nframes = (phase == 1) ? 3 : 1;
      repeat (nframes) queue_random_frame();
      wait_drained();
      phase++;
    end

    rx_steady  = 1'b0;
    res_steady = 1'b0;
    repeat (10) @(posedge clk);
    if (mismatches == 0 && reply_due.size() == 0) begin
      $display("tb_modbus_rtu_read_response_checker: done, clean");
    end else begin
      $display("tb_modbus_rtu_read_response_checker: done, errors");
    end
    $finish;
  end

endmodule
